// ===== rtl/kwsm_pkg.sv =====
package kwsm_pkg;

	// Sizing of the merge.
	localparam int STREAMS    = 8;
	localparam int VALUE_BITS = 32;

	// Derived widths.
	localparam int SIDX_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int BIT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	// Fixed field widths of the channels.
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;
	localparam int CFG_W  = 4;

	// Reset value of the stream count register.
	localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(2);

	// Input actions.
	localparam logic ACT_VALUE = 1'b0;
	localparam logic ACT_END   = 1'b1;

	typedef logic signed [VALUE_BITS-1:0] head_t;

	typedef struct packed {
		logic                     action;
		logic [IDX_W-1:0]         stream_index;
		logic signed [DATA_W-1:0] data_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] merged_value;
		logic [IDX_W-1:0]         source_stream;
		logic                     finished;
	} out_item_t;

	// Control from the sequencer to the bit-serial minimum search.
	typedef struct packed {
		logic start;
		logic step;
		logic sign_bit;
	} srch_ctl_t;

	// Sign-extend (or truncate) an input value to the head width.
	function automatic head_t to_head(input logic signed [DATA_W-1:0] d);
		return VALUE_BITS'(d);
	endfunction

	// Give a head back at the output width, sign-extended or truncated.
	function automatic logic signed [DATA_W-1:0] to_out(input head_t h);
		return DATA_W'(h);
	endfunction

endpackage

// ===== rtl/kwsm_head_bank.sv =====
module kwsm_head_bank (
	input  logic                                 clk,
	input  logic [kwsm_pkg::STREAMS-1:0]         load_sel,
	input  kwsm_pkg::head_t                      load_value,
	input  logic                                 rotate,
	input  logic [kwsm_pkg::SIDX_W-1:0]          rd_sel,
	output logic [kwsm_pkg::STREAMS-1:0]         msb,
	output kwsm_pkg::head_t                      rd_value
);

	kwsm_pkg::head_t head_q [kwsm_pkg::STREAMS];

	// Each head is a circular shift register that presents its top bit first.
	// A full rotation through all VALUE_BITS bit positions brings every head back in place.
	always_ff @(posedge clk) begin
		for (int i = 0; i < kwsm_pkg::STREAMS; i++) begin
			if (load_sel[i]) begin
				head_q[i] <= load_value;
			end else if (rotate) begin
				head_q[i] <= {head_q[i][kwsm_pkg::VALUE_BITS-2:0],
					head_q[i][kwsm_pkg::VALUE_BITS-1]};
			end
		end
	end

	// Serial taps, one bit per stream.
	always_comb begin
		for (int i = 0; i < kwsm_pkg::STREAMS; i++) begin
			msb[i] = head_q[i][kwsm_pkg::VALUE_BITS-1];
		end
	end

	// Parallel read of the chosen head once the rotation is complete.
	assign rd_value = head_q[rd_sel];

endmodule

// ===== rtl/kwsm_min_search.sv =====
module kwsm_min_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  kwsm_pkg::srch_ctl_t                  ctl,
	input  logic [kwsm_pkg::STREAMS-1:0]         init_cand,
	input  logic [kwsm_pkg::STREAMS-1:0]         key_in,
	output logic [kwsm_pkg::SIDX_W-1:0]          winner
);

	logic [kwsm_pkg::STREAMS-1:0] cand_q;
	logic [kwsm_pkg::STREAMS-1:0] kbit;
	logic [kwsm_pkg::STREAMS-1:0] zero_cand;

	// The sign bit is inverted so that an unsigned compare orders signed values.
	assign kbit      = ctl.sign_bit ? ~key_in : key_in;
	assign zero_cand = cand_q & ~kbit;

	// Drop candidates with a one where some candidate has a zero, top bit first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (ctl.start) begin
			cand_q <= init_cand;
		end else if (ctl.step && (|zero_cand)) begin
			cand_q <= zero_cand;
		end
	end

	// The lowest surviving index wins ties.
	always_comb begin
		winner = '0;
		for (int i = kwsm_pkg::STREAMS - 1; i >= 0; i--) begin
			if (cand_q[i]) begin
				winner = kwsm_pkg::SIDX_W'(i);
			end
		end
	end

endmodule

// ===== rtl/k_way_sorted_merge_core.sv =====
// Channel   Direction  Beat content                     Handshake
// item      in         action, stream_index, data_value item_valid / item_ready
// result    out        merged_value, source_stream,     result_valid / result_ready
//                      finished
// cfg       in         stream_count                     cfg_valid / cfg_ready
//
// An item without a result passes from CHECK back to IDLE, and one that gives the finished
// result goes on from CHECK to EMIT; an item that gives a merged value first passes SEARCH,
// the bit-serial minimum search that walks all heads one bit per cycle, top first, then EMIT.
// Reset is asynchronous and active low; it clears the valid and ended flags and the
// result valid, and sets the stream count back to 2; head values need no reset.
// A stalled result waits in its output register while the next item is taken.
module k_way_sorted_merge_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  kwsm_pkg::in_item_t           item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output kwsm_pkg::out_item_t          result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [kwsm_pkg::CFG_W-1:0]   cfg_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_CHECK  = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]                       state_q;
	logic [kwsm_pkg::CFG_W-1:0]       count_q;
	logic [kwsm_pkg::STREAMS-1:0]     valid_q;
	logic [kwsm_pkg::STREAMS-1:0]     ended_q;
	logic                             fin_rep_q;
	logic                             fin_q;
	logic [kwsm_pkg::BIT_W-1:0]       bit_q;
	logic                             out_valid_q;
	kwsm_pkg::out_item_t              out_q;

	logic [kwsm_pkg::STREAMS-1:0]     active;
	logic [kwsm_pkg::STREAMS-1:0]     hit;
	logic [kwsm_pkg::STREAMS-1:0]     load_sel;
	logic [kwsm_pkg::STREAMS-1:0]     win_sel;
	logic [kwsm_pkg::STREAMS-1:0]     msb;
	logic [kwsm_pkg::SIDX_W-1:0]      winner;
	kwsm_pkg::head_t                  rd_value;
	kwsm_pkg::srch_ctl_t              srch_ctl;
	logic                             item_beat;
	logic                             all_ready;
	logic                             any_head;
	logic                             last_bit;
	logic                             out_free;
	logic                             emit_go;

	// Streams taking part; a count of zero still keeps stream 0.
	always_comb begin
		for (int i = 0; i < kwsm_pkg::STREAMS; i++) begin
			active[i]  = (i == 0) || (i < int'(count_q));
			hit[i]     = active[i] && (int'(item.stream_index) == i);
			win_sel[i] = (int'(winner) == i);
		end
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign item_beat    = item_valid && item_ready;
	assign cfg_ready    = 1'b1;
	assign load_sel     = (item_beat && (item.action == kwsm_pkg::ACT_VALUE)) ?
		(hit & ~valid_q & ~ended_q) : '0;
	assign all_ready    = &(~active | valid_q | ended_q);
	assign any_head     = |(active & valid_q);
	assign last_bit     = (bit_q == kwsm_pkg::BIT_W'(kwsm_pkg::VALUE_BITS - 1));
	assign out_free     = !out_valid_q || result_ready;
	assign emit_go      = (state_q == ST_EMIT) && out_free;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Search control toward the serial comparator.
	assign srch_ctl.start    = (state_q == ST_CHECK);
	assign srch_ctl.step     = (state_q == ST_SEARCH);
	assign srch_ctl.sign_bit = (bit_q == '0);

	kwsm_head_bank u_bank (
		.clk        (clk),
		.load_sel   (load_sel),
		.load_value (kwsm_pkg::to_head(item.data_value)),
		.rotate     (srch_ctl.step),
		.rd_sel     (winner),
		.msb        (msb),
		.rd_value   (rd_value)
	);

	kwsm_min_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (srch_ctl),
		.init_cand (active & valid_q),
		.key_in    (msb),
		.winner    (winner)
	);

	// Stream count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= kwsm_pkg::COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// Sequencer: take an item, check the heads, search if a head waits, emit if due.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			ended_q   <= '0;
			fin_rep_q <= 1'b0;
			fin_q     <= 1'b0;
			bit_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_beat) begin
						if (item.action == kwsm_pkg::ACT_END) begin
							ended_q <= ended_q | hit;
						end
						valid_q <= valid_q | load_sel;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					bit_q <= '0;
					fin_q <= 1'b0;
					if (!all_ready) begin
						state_q <= ST_IDLE;
					end else if (any_head) begin
						state_q <= ST_SEARCH;
					end else if (!fin_rep_q) begin
						fin_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEARCH: begin
					bit_q <= bit_q + 1'b1;
					if (last_bit) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (fin_q) begin
							fin_rep_q <= 1'b1;
						end else begin
							valid_q <= valid_q & ~win_sel;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register; holds a beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			if (fin_q) begin
				out_q.merged_value  <= '0;
				out_q.source_stream <= '0;
				out_q.finished      <= 1'b1;
			end else begin
				out_q.merged_value  <= kwsm_pkg::to_out(rd_value);
				out_q.source_stream <= kwsm_pkg::IDX_W'(winner);
				out_q.finished      <= 1'b0;
			end
		end
	end

endmodule
